>>> rtl/core/cfpt_pkg.sv
// ----------------------------------------------------------------------------
// cfpt_pkg
// shared constants and types of the camera frame point transform
// ----------------------------------------------------------------------------
package cfpt_pkg;

	localparam int PT_W     = 32;
	localparam int AX_W     = 48;
	localparam int DIV_BITS = 48;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [31:0] Q16_ONE = 32'sd65536;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAM_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd5;

	// modes
	localparam logic [1:0] MODE_XF  = 2'd0;
	localparam logic [1:0] MODE_DIV = 2'd1;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_ZERODIV  = 2'd2;
	localparam logic [1:0] ST_SAT      = 2'd3;

	typedef logic [8:0][31:0] inv_mat_t;

	typedef struct packed {
		logic ready;
		logic singular;
		logic sat;
	} inv_st_t;

	typedef struct packed {
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic signed [31:0] ez;
		logic               sing;
		logic               zero;
		logic               sat;
	} dv_tag_t;

endpackage

>>> rtl/core/camera_frame_point_transform.sv
// ----------------------------------------------------------------------------
// camera_frame_point_transform
// camera frame change of 3-d points with optional perspective divide
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tdata: point_x, point_y, point_z (q16.16)
//  m_*      | out       | tdata: out_x, out_y, out_z; tuser: status
//  cfg_*    | in        | cfg_index selects register, cfg_data value
//
//  one item per cycle sustained unless m_tready or an inverse rebuild stalls;
//  stages: three transform, one divider entry, 48 quotient-bit, divider exit,
//  output; after reset and after each axis write the inverse sequencer runs
//  its 21 multiply steps and 9 entries of 81 divide steps, s_tready low
//  a stall on m_tready freezes the whole pipeline at once, nothing is lost
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module camera_frame_point_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,    // point_x, point_y, point_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,    // out_x, out_y, out_z
	output logic [7:0]  m_tuser,    // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	// configuration
	logic signed [31:0] cam_q [3];
	logic [47:0]        horizon_q, normal_q;
	logic [1:0]         mode_q;
	logic               cfg_wr, axis_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign axis_wr   = cfg_wr && (cfg_index == cfpt_pkg::REG_HORIZON ||
	                              cfg_index == cfpt_pkg::REG_NORMAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0]  <= '0;
			cam_q[1]  <= '0;
			cam_q[2]  <= '0;
			horizon_q <= 48'd16384;
			normal_q  <= 48'd1073741824;
			mode_q    <= cfpt_pkg::MODE_XF;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				cfpt_pkg::REG_CAM_X:   cam_q[0]  <= cfg_data[31:0];
				cfpt_pkg::REG_CAM_Y:   cam_q[1]  <= cfg_data[31:0];
				cfpt_pkg::REG_CAM_Z:   cam_q[2]  <= cfg_data[31:0];
				cfpt_pkg::REG_HORIZON: horizon_q <= cfg_data;
				cfpt_pkg::REG_NORMAL:  normal_q  <= cfg_data;
				cfpt_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// mode 3 runs as transform then divide
	logic xf_on, dv_on;
	assign xf_on = mode_q != cfpt_pkg::MODE_DIV;
	assign dv_on = mode_q != cfpt_pkg::MODE_XF;

	// inverse basis
	cfpt_pkg::inv_mat_t inv;
	cfpt_pkg::inv_st_t  inv_st;

	cfpt_inv_build u_inv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (axis_wr),
		.horizon (horizon_q),
		.normal  (normal_q),
		.inv     (inv),
		.st      (inv_st)
	);

	// global pipeline advance
	logic out_vld_q, en;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en & inv_st.ready;

	// stage 1: point and offset from camera
	logic               v_s1;
	logic signed [31:0] p_s1   [3];
	logic signed [32:0] dlt_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid & s_tready;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]   <= s_tdata[32*i +: 32];
				dlt_s1[i] <= 33'($signed(s_tdata[32*i +: 32])) - 33'(cam_q[i]);
			end
		end
	end

	// stage 2: nine products of inverse entries and offsets
	logic               v_s2;
	logic signed [64:0] prod_s2 [9];
	logic signed [31:0] p_s2    [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= p_s1[i];
				for (int j = 0; j < 3; j++)
					prod_s2[i*3+j] <= 65'($signed(inv[i*3+j])) * 65'(dlt_s1[j]);
			end
		end
	end

	// stage 3: round half up, sum rows, saturate; mode picks point or result
	function automatic logic signed [50:0] rnd(input logic signed [64:0] x);
		logic signed [64:0] t;
		t = x + 65'sd32768;
		return 51'($signed(t[64:16]));
	endfunction

	logic               v_s3;
	logic signed [31:0] e_s3 [3];
	logic               sat_s3;
	logic signed [50:0] row_sum [3];
	logic signed [31:0] row_e   [3];
	logic [2:0]         row_sat;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = rnd(prod_s2[i*3]) + rnd(prod_s2[i*3+1]) + rnd(prod_s2[i*3+2]);
			row_sat[i] = 1'b1;
			if (row_sum[i] > 51'(cfpt_pkg::S32_MAX))      row_e[i] = cfpt_pkg::S32_MAX;
			else if (row_sum[i] < 51'(cfpt_pkg::S32_MIN)) row_e[i] = cfpt_pkg::S32_MIN;
			else begin
				row_e[i]   = row_sum[i][31:0];
				row_sat[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) e_s3[i] <= xf_on ? row_e[i] : p_s2[i];
			sat_s3 <= xf_on & ((|row_sat) | inv_st.sat);
		end
	end

	// divider, with the transform result riding alongside
	cfpt_pkg::dv_tag_t  tag_in, tag_out;
	logic               dv_vld, q_sat;
	logic signed [31:0] q_x, q_z;

	always_comb begin
		tag_in.ex   = e_s3[0];
		tag_in.ey   = e_s3[1];
		tag_in.ez   = e_s3[2];
		tag_in.sing = xf_on & inv_st.singular;
		tag_in.zero = e_s3[1] == '0;
		tag_in.sat  = sat_s3;
	end

	cfpt_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num_x     (e_s3[0]),
		.num_z     (e_s3[2]),
		.den       (e_s3[1]),
		.tag_in    (tag_in),
		.out_valid (dv_vld),
		.q_x       (q_x),
		.q_z       (q_z),
		.q_sat     (q_sat),
		.tag_out   (tag_out)
	);

	// output register: status priority singular, zero divisor, saturation
	logic [95:0] out_data_q;
	logic [1:0]  out_st_q;
	logic [95:0] res_data;
	logic [1:0]  res_st;

	always_comb begin
		priority if (tag_out.sing) begin
			res_data = '0;
			res_st   = cfpt_pkg::ST_SINGULAR;
		end else if (dv_on && tag_out.zero) begin
			res_data = '0;
			res_st   = cfpt_pkg::ST_ZERODIV;
		end else if (!dv_on) begin
			res_data = {tag_out.ez, tag_out.ey, tag_out.ex};
			res_st   = tag_out.sat ? cfpt_pkg::ST_SAT : cfpt_pkg::ST_OK;
		end else begin
			res_data = {q_z, cfpt_pkg::Q16_ONE, q_x};
			res_st   = (tag_out.sat | q_sat) ? cfpt_pkg::ST_SAT : cfpt_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res_data;
			out_st_q   <= res_st;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {6'b0, out_st_q};

	// no items are taken while the inverse is being rebuilt
	a_rdy_inv: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> inv_st.ready)
		else $error("input taken without a valid inverse");

	a_axis_block: assert property (@(posedge clk) disable iff (!arst_n)
		axis_wr |=> !s_tready)
		else $error("input open right after an axis write");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] == cfpt_pkg::ST_SINGULAR ||
		              m_tuser[1:0] == cfpt_pkg::ST_ZERODIV)) |-> m_tdata == '0)
		else $error("error item with nonzero coordinates");

endmodule

>>> rtl/core/cfpt_inv_build.sv
// ----------------------------------------------------------------------------
// cfpt_inv_build
// sequencer that forms the inverse camera basis from the two axis registers
// ----------------------------------------------------------------------------
module cfpt_inv_build (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [47:0]         horizon,
	input  logic [47:0]         normal,
	output cfpt_pkg::inv_mat_t  inv,
	output cfpt_pkg::inv_st_t   st
);

	localparam logic [2:0] ST_MUL  = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_IDLE = 3'd4;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;

	localparam logic [4:0] LAST_STEP  = 5'd20;
	localparam logic [3:0] LAST_ENTRY = 4'd8;
	localparam int         DVD_W      = 81;
	localparam logic [6:0] LAST_BIT   = 7'd80;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [1:0] op;
	} step_t;

	logic [2:0]          state_q;
	logic [4:0]          step_q;
	logic signed [67:0]  prod_q;
	logic signed [65:0]  acc_q;
	logic signed [32:0]  v_q [3];
	logic signed [49:0]  a_q [3];
	logic signed [49:0]  c_q [3];
	logic [63:0]         d_q;
	logic [1:0]          row_q;
	logic [1:0]          col_q;
	logic [3:0]          entry_q;
	logic [6:0]          bit_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [63:0]         rem_q;
	logic [33:0]         quo_q;
	logic                big_q;
	logic                neg_q;
	logic                sat_q;
	logic                sing_q;
	logic                ready_q;
	cfpt_pkg::inv_mat_t  inv_q;

	function automatic step_t step_dec(input logic [4:0] s);
		step_t r;
		unique case (s)
			5'd0:    r = '{4'd1, 4'd5, OP_LOAD};
			5'd1:    r = '{4'd2, 4'd4, OP_SUB};
			5'd2:    r = '{4'd2, 4'd3, OP_LOAD};
			5'd3:    r = '{4'd0, 4'd5, OP_SUB};
			5'd4:    r = '{4'd0, 4'd4, OP_LOAD};
			5'd5:    r = '{4'd1, 4'd3, OP_SUB};
			5'd6:    r = '{4'd6, 4'd6, OP_LOAD};
			5'd7:    r = '{4'd7, 4'd7, OP_ADD};
			5'd8:    r = '{4'd8, 4'd8, OP_ADD};
			5'd9:    r = '{4'd7, 4'd5, OP_LOAD};
			5'd10:   r = '{4'd8, 4'd4, OP_SUB};
			5'd11:   r = '{4'd8, 4'd3, OP_LOAD};
			5'd12:   r = '{4'd6, 4'd5, OP_SUB};
			5'd13:   r = '{4'd6, 4'd4, OP_LOAD};
			5'd14:   r = '{4'd7, 4'd3, OP_SUB};
			5'd15:   r = '{4'd1, 4'd8, OP_LOAD};
			5'd16:   r = '{4'd2, 4'd7, OP_SUB};
			5'd17:   r = '{4'd2, 4'd6, OP_LOAD};
			5'd18:   r = '{4'd0, 4'd8, OP_SUB};
			5'd19:   r = '{4'd0, 4'd7, OP_LOAD};
			5'd20:   r = '{4'd1, 4'd6, OP_SUB};
			default: r = '{4'd0, 4'd0, OP_LOAD};
		endcase
		return r;
	endfunction

	function automatic logic signed [33:0] pick(input logic [3:0] sel,
		input logic [47:0] h, input logic [47:0] n,
		input logic signed [32:0] v0, input logic signed [32:0] v1,
		input logic signed [32:0] v2);
		logic signed [33:0] r;
		unique case (sel)
			4'd0:    r = 34'($signed(h[15:0]));
			4'd1:    r = 34'($signed(h[31:16]));
			4'd2:    r = 34'($signed(h[47:32]));
			4'd3:    r = 34'($signed(n[15:0]));
			4'd4:    r = 34'($signed(n[31:16]));
			4'd5:    r = 34'($signed(n[47:32]));
			4'd6:    r = 34'(v0);
			4'd7:    r = 34'(v1);
			4'd8:    r = 34'(v2);
			default: r = '0;
		endcase
		return r;
	endfunction

	step_t               stp;
	logic signed [33:0]  opa, opb;
	logic signed [65:0]  acc_nx;
	logic signed [50:0]  num;
	logic                num_neg;
	logic [49:0]         num_mag;
	logic [64:0]         r_try;
	logic                q_bit;
	logic [64:0]         r_sub;
	logic [33:0]         quo_nx;
	logic                big_nx;
	logic                ovf;
	logic [31:0]         ent_val;

	always_comb begin
		stp = step_dec(step_q);
		opa = pick(stp.a, horizon, normal, v_q[0], v_q[1], v_q[2]);
		opb = pick(stp.b, horizon, normal, v_q[0], v_q[1], v_q[2]);
		unique case (stp.op)
			OP_ADD:  acc_nx = acc_q + prod_q[65:0];
			OP_SUB:  acc_nx = acc_q - prod_q[65:0];
			default: acc_nx = prod_q[65:0];
		endcase
	end

	// numerator of the next entry
	always_comb begin
		unique case (row_q)
			2'd0:    num = -51'(a_q[col_q]);
			2'd1:    num = 51'(v_q[col_q]);
			default: num = -51'(c_q[col_q]);
		endcase
		num_neg = num[50];
		num_mag = num_neg ? 50'(-num) : num[49:0];
	end

	// one restoring step
	always_comb begin
		r_try  = {rem_q, dvd_q[DVD_W-1]};
		q_bit  = r_try >= {1'b0, d_q};
		r_sub  = r_try - {1'b0, d_q};
		quo_nx = {quo_q[32:0], q_bit};
		big_nx = big_q | quo_q[32];
		if (neg_q) begin
			ovf     = big_nx || (quo_nx > 34'h080000000);
			ent_val = ovf ? cfpt_pkg::S32_MIN : 32'(~quo_nx[31:0] + 32'd1);
		end else begin
			ovf     = big_nx || (quo_nx > 34'h07fffffff);
			ent_val = ovf ? cfpt_pkg::S32_MAX : quo_nx[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
			step_q  <= '0;
			ready_q <= 1'b0;
			sing_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else if (start) begin
			state_q <= ST_MUL;
			step_q  <= '0;
			ready_q <= 1'b0;
			sing_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_PREP;
					end else begin
						step_q  <= step_q + 5'd1;
						state_q <= ST_MUL;
					end
				end
				ST_PREP: begin
					if (d_q == '0) begin
						sing_q  <= 1'b1;
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						sat_q <= sat_q | ovf;
						if (entry_q == LAST_ENTRY) begin
							ready_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// entry counters restart while the products run
		if (state_q == ST_MUL) begin
			row_q   <= '0;
			col_q   <= '0;
			entry_q <= '0;
		end
		unique case (state_q)
			ST_MUL: begin
				prod_q <= opa * opb;
			end
			ST_ACC: begin
				acc_q <= acc_nx;
				unique case (step_q)
					5'd1:    v_q[0] <= acc_nx[32:0];
					5'd3:    v_q[1] <= acc_nx[32:0];
					5'd5:    v_q[2] <= acc_nx[32:0];
					5'd8:    d_q    <= acc_nx[63:0];
					5'd10:   a_q[0] <= acc_nx[49:0];
					5'd12:   a_q[1] <= acc_nx[49:0];
					5'd14:   a_q[2] <= acc_nx[49:0];
					5'd16:   c_q[0] <= acc_nx[49:0];
					5'd18:   c_q[1] <= acc_nx[49:0];
					5'd20:   c_q[2] <= acc_nx[49:0];
					default: begin
					end
				endcase
			end
			ST_PREP: begin
				neg_q <= num_neg;
				rem_q <= '0;
				quo_q <= '0;
				big_q <= 1'b0;
				bit_q <= LAST_BIT;
				dvd_q <= (row_q == 2'd1) ? (DVD_W'(num_mag) << 44)
				                        : (DVD_W'(num_mag) << 30);
			end
			ST_DIV: begin
				rem_q <= q_bit ? r_sub[63:0] : r_try[63:0];
				quo_q <= quo_nx;
				big_q <= big_nx;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				bit_q <= bit_q - 7'd1;
				if (bit_q == '0) begin
					inv_q[entry_q] <= ent_val;
					entry_q        <= entry_q + 4'd1;
					if (col_q == 2'd2) begin
						col_q <= '0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign inv         = inv_q;
	assign st.ready    = ready_q;
	assign st.singular = sing_q;
	assign st.sat      = sat_q;

endmodule

>>> rtl/core/cfpt_div_pipe.sv
// ----------------------------------------------------------------------------
// cfpt_div_pipe
// pipelined signed divider, one quotient bit per stage, x and z lanes
// ----------------------------------------------------------------------------
module cfpt_div_pipe (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [31:0]       num_x,
	input  logic signed [31:0]       num_z,
	input  logic signed [31:0]       den,
	input  cfpt_pkg::dv_tag_t        tag_in,
	output logic                     out_valid,
	output logic signed [31:0]       q_x,
	output logic signed [31:0]       q_z,
	output logic                     q_sat,
	output cfpt_pkg::dv_tag_t        tag_out
);

	localparam int NB = cfpt_pkg::DIV_BITS;

	logic [31:0]        rem_x_s  [NB+1];
	logic [31:0]        rem_z_s  [NB+1];
	logic [NB-1:0]      work_x_s [NB+1];
	logic [NB-1:0]      work_z_s [NB+1];
	logic [31:0]        dm_s     [NB+1];
	logic               ngx_s    [NB+1];
	logic               ngz_s    [NB+1];
	cfpt_pkg::dv_tag_t  tag_s    [NB+1];
	logic               vld_s    [NB+1];

	logic [31:0]        rem_x_n  [NB+1];
	logic [31:0]        rem_z_n  [NB+1];
	logic [NB-1:0]      work_x_n [NB+1];
	logic [NB-1:0]      work_z_n [NB+1];

	logic               vld_sout;
	logic signed [31:0] qx_sout, qz_sout;
	logic               sat_sout;
	cfpt_pkg::dv_tag_t  tag_sout;

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		logic [32:0] e;
		e = {a[31], a};
		return a[31] ? 32'(-e) : a;
	endfunction

	// restoring steps, one per stage
	always_comb begin
		logic [32:0] rx, rz;
		rem_x_n[0]  = '0;
		rem_z_n[0]  = '0;
		work_x_n[0] = '0;
		work_z_n[0] = '0;
		for (int k = 1; k <= NB; k++) begin
			rx = {rem_x_s[k-1], work_x_s[k-1][NB-1]};
			rz = {rem_z_s[k-1], work_z_s[k-1][NB-1]};
			if (rx >= {1'b0, dm_s[k-1]}) begin
				rem_x_n[k]  = 32'(rx - {1'b0, dm_s[k-1]});
				work_x_n[k] = {work_x_s[k-1][NB-2:0], 1'b1};
			end else begin
				rem_x_n[k]  = rx[31:0];
				work_x_n[k] = {work_x_s[k-1][NB-2:0], 1'b0};
			end
			if (rz >= {1'b0, dm_s[k-1]}) begin
				rem_z_n[k]  = 32'(rz - {1'b0, dm_s[k-1]});
				work_z_n[k] = {work_z_s[k-1][NB-2:0], 1'b1};
			end else begin
				rem_z_n[k]  = rz[31:0];
				work_z_n[k] = {work_z_s[k-1][NB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NB; k++) vld_s[k] <= 1'b0;
			vld_sout <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= NB; k++) vld_s[k] <= vld_s[k-1];
			vld_sout <= vld_s[NB];
		end
	end

	function automatic logic signed [31:0] fin(input logic [NB-1:0] q, input logic ng,
		output logic ovf);
		if (ng) begin
			ovf = q > NB'(33'h080000000);
			return ovf ? cfpt_pkg::S32_MIN : 32'(~q[31:0] + 32'd1);
		end
		ovf = q > NB'(33'h07fffffff);
		return ovf ? cfpt_pkg::S32_MAX : q[31:0];
	endfunction

	logic               ovx, ovz;
	logic signed [31:0] fx, fz;

	always_comb begin
		fx = fin(work_x_s[NB], ngx_s[NB], ovx);
		fz = fin(work_z_s[NB], ngz_s[NB], ovz);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_s[0]  <= '0;
			rem_z_s[0]  <= '0;
			work_x_s[0] <= {mag32(num_x), 16'b0};
			work_z_s[0] <= {mag32(num_z), 16'b0};
			dm_s[0]     <= mag32(den);
			ngx_s[0]    <= num_x[31] ^ den[31];
			ngz_s[0]    <= num_z[31] ^ den[31];
			tag_s[0]    <= tag_in;
			for (int k = 1; k <= NB; k++) begin
				rem_x_s[k]  <= rem_x_n[k];
				rem_z_s[k]  <= rem_z_n[k];
				work_x_s[k] <= work_x_n[k];
				work_z_s[k] <= work_z_n[k];
				dm_s[k]     <= dm_s[k-1];
				ngx_s[k]    <= ngx_s[k-1];
				ngz_s[k]    <= ngz_s[k-1];
				tag_s[k]    <= tag_s[k-1];
			end
			qx_sout  <= fx;
			qz_sout  <= fz;
			sat_sout <= ovx | ovz;
			tag_sout <= tag_s[NB];
		end
	end

	assign out_valid = vld_sout;
	assign q_x       = qx_sout;
	assign q_z       = qz_sout;
	assign q_sat     = sat_sout;
	assign tag_out   = tag_sout;

endmodule

>>> tb/sv/camera_frame_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_frame_point_checker
// watches the config, point and result channels, predicts each transformed
// point from its own copy of the registers and inverse basis, and compares
// ----------------------------------------------------------------------------
module camera_frame_point_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [7:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam logic [1:0] MODE_BOTH = 2'd2;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [7:0]  st;
	} cam_point_t;

	cam_point_t expected_points[$];

	logic signed [31:0] cam_x, cam_y, cam_z;
	logic [47:0]        horizon, normal;
	logic [1:0]         mode_reg;
	logic signed [31:0] inv_m [9];
	logic               inv_singular, inv_sat;

	assign pending = expected_points.size();

	function automatic logic [31:0] clip32(input logic signed [127:0] x, inout logic sat);
		if (x > 128'sh7fffffff) begin
			sat = 1'b1;
			return cfpt_pkg::S32_MAX;
		end
		if (x < -128'sh80000000) begin
			sat = 1'b1;
			return cfpt_pkg::S32_MIN;
		end
		return x[31:0];
	endfunction

	// (num * 2^sh) / den, truncated toward zero, clipped to 32 bits
	function automatic logic [31:0] scaled_quot(input longint num, input int sh,
			input logic [127:0] den, inout logic sat);
		logic [127:0] mag, q;
		mag = (num < 0) ? 128'(-num) : 128'(num);
		q = (mag << sh) / den;
		if (num < 0) begin
			if (q > 128'h80000000) begin
				sat = 1'b1;
				return cfpt_pkg::S32_MIN;
			end
			return 32'(-q);
		end
		if (q > 128'h7fffffff) begin
			sat = 1'b1;
			return cfpt_pkg::S32_MAX;
		end
		return q[31:0];
	endfunction

	task automatic rebuild_inverse();
		longint h[3], n[3], v[3], a[3], c[3];
		logic [127:0] d;
		logic sat;
		sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			h[k] = longint'($signed(horizon[16*k +: 16]));
			n[k] = longint'($signed(normal[16*k +: 16]));
		end
		v[0] = h[1] * n[2] - h[2] * n[1];
		v[1] = h[2] * n[0] - h[0] * n[2];
		v[2] = h[0] * n[1] - h[1] * n[0];
		d = 128'(v[0] * v[0]) + 128'(v[1] * v[1]) + 128'(v[2] * v[2]);
		inv_singular = (d == 0);
		inv_sat = 1'b0;
		for (int k = 0; k < 9; k++) inv_m[k] = '0;
		if (!inv_singular) begin
			a[0] = v[1] * n[2] - v[2] * n[1];
			a[1] = v[2] * n[0] - v[0] * n[2];
			a[2] = v[0] * n[1] - v[1] * n[0];
			c[0] = h[1] * v[2] - h[2] * v[1];
			c[1] = h[2] * v[0] - h[0] * v[2];
			c[2] = h[0] * v[1] - h[1] * v[0];
			for (int k = 0; k < 3; k++) begin
				inv_m[k]     = scaled_quot(-a[k], 30, d, sat);
				inv_m[3 + k] = scaled_quot(v[k], 44, d, sat);
				inv_m[6 + k] = scaled_quot(-c[k], 30, d, sat);
			end
			inv_sat = sat;
		end
	endtask

	function automatic cam_point_t project_point(input logic [95:0] pt);
		cam_point_t r;
		logic signed [127:0] e[3], dlt[3], acc, t, q;
		logic sat;
		logic [1:0] m;
		sat = 1'b0;
		m = (mode_reg == 2'd3) ? MODE_BOTH : mode_reg;
		for (int i = 0; i < 3; i++) e[i] = $signed(pt[32*i +: 32]);
		if (m != cfpt_pkg::MODE_DIV) begin
			if (inv_singular) begin
				r = '{32'd0, 32'd0, 32'd0, {6'd0, cfpt_pkg::ST_SINGULAR}};
				return r;
			end
			sat = inv_sat;
			dlt[0] = e[0] - cam_x;
			dlt[1] = e[1] - cam_y;
			dlt[2] = e[2] - cam_z;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) begin
					t = inv_m[3*i + j];
					t = t * dlt[j] + 32768;
					acc += t >>> 16;
				end
				e[i] = $signed(clip32(acc, sat));
			end
		end
		if (m != cfpt_pkg::MODE_XF) begin
			// zero divisor wins over saturation
			if (e[1] == 0) begin
				r = '{32'd0, 32'd0, 32'd0, {6'd0, cfpt_pkg::ST_ZERODIV}};
				return r;
			end
			q = (e[0] * 65536) / e[1];
			e[0] = $signed(clip32(q, sat));
			q = (e[2] * 65536) / e[1];
			e[2] = $signed(clip32(q, sat));
			e[1] = cfpt_pkg::Q16_ONE;
		end
		r.x = e[0][31:0];
		r.y = e[1][31:0];
		r.z = e[2][31:0];
		r.st = {6'd0, sat ? cfpt_pkg::ST_SAT : cfpt_pkg::ST_OK};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cam_point_t want;
		if (!arst_n) begin
			cam_x = '0;
			cam_y = '0;
			cam_z = '0;
			horizon = 48'd16384;
			normal = 48'd1073741824;
			mode_reg = cfpt_pkg::MODE_XF;
			fail_count = 0;
			expected_points.delete();
			rebuild_inverse();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cfpt_pkg::REG_CAM_X: cam_x = cfg_data[31:0];
					cfpt_pkg::REG_CAM_Y: cam_y = cfg_data[31:0];
					cfpt_pkg::REG_CAM_Z: cam_z = cfg_data[31:0];
					cfpt_pkg::REG_HORIZON: begin
						horizon = cfg_data;
						rebuild_inverse();
					end
					cfpt_pkg::REG_NORMAL: begin
						normal = cfg_data;
						rebuild_inverse();
					end
					cfpt_pkg::REG_MODE: mode_reg = cfg_data[1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_points.push_back(project_point(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %h / %h", $time, m_tdata, m_tuser);
				end else begin
					want = expected_points.pop_front();
					if (m_tdata[31:0] !== want.x) begin
						fail_count++;
						$display("%0t: out_x expected %h actual %h", $time, want.x,
							m_tdata[31:0]);
					end
					if (m_tdata[63:32] !== want.y) begin
						fail_count++;
						$display("%0t: out_y expected %h actual %h", $time, want.y,
							m_tdata[63:32]);
					end
					if (m_tdata[95:64] !== want.z) begin
						fail_count++;
						$display("%0t: out_z expected %h actual %h", $time, want.z,
							m_tdata[95:64]);
					end
					if (m_tuser !== want.st) begin
						fail_count++;
						$display("%0t: status expected %h actual %h", $time, want.st,
							m_tuser);
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/tb_camera_frame_point_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_camera_frame_point_transform
// drives points and register settings into the point transform with random
// gaps and back-pressure; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_camera_frame_point_transform;

	localparam logic [1:0] MODE_BOTH     = 2'd2;
	localparam logic [1:0] MODE_BOTH_ALT = 2'd3;
	localparam logic [2:0] REG_UNUSED    = 3'd7;
	localparam int         DRAIN_CYCLES  = 80;    // pipeline is 54 deep
	localparam int         STALL_LIMIT   = 5000;  // longer than an inverse rebuild
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [15:0] AX_ONE = 16'sd16384;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;     // point_x, point_y, point_z
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;          // out_x, out_y, out_z
	logic [7:0]  m_tuser;          // status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int rx_stall = 0;
	bit calm = 1'b0;     // no idling on either side while set

	always #5 clk = ~clk;

	camera_frame_point_transform DUT (.*);

	camera_frame_point_checker checker_i (.*);

	// short gaps mostly, now and then a long one
	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_stall <= idle_len();
		end
	end

	// watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [47:0] axis(input logic [15:0] ax, ay, az);
		return {az, ay, ax};
	endfunction

	// valid stays high across back-to-back items, dropped only for a gap
	task automatic send_point(input logic [31:0] px, py, pz);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pz, py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop sending and let every outstanding item come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [31:0] cx, cy, cz, input logic [47:0] h, n,
			input logic [1:0] m);
		drain();
		write_reg(cfpt_pkg::REG_CAM_X, {16'($urandom_range(0, 65535)), cx});
		write_reg(cfpt_pkg::REG_CAM_Y, {16'd0, cy});
		write_reg(cfpt_pkg::REG_CAM_Z, {16'd0, cz});
		write_reg(cfpt_pkg::REG_HORIZON, h);
		write_reg(cfpt_pkg::REG_NORMAL, n);
		write_reg(cfpt_pkg::REG_MODE, {$urandom, 14'd0, m});
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic random_phase(input int count);
		logic [31:0] c[3], p[3];
		logic [15:0] hx, hy, hz;
		logic [47:0] h, n;
		int r;
		hx = rand_comp();
		hy = rand_comp();
		hz = rand_comp();
		h = axis(hx, hy, hz);
		r = $urandom_range(0, 99);
		if (r < 60) n = axis(rand_comp(), rand_comp(), rand_comp());
		else if (r < 72) begin
			h = 48'({$urandom, $urandom});
			n = 48'({$urandom, $urandom});
		end else if (r < 84) n = h;                       // parallel axes
		else begin
			// tiny axes push the inverse out of range
			h = axis(16'($urandom_range(0, 6) - 3), 16'($urandom_range(0, 6) - 3),
				16'($urandom_range(0, 2)));
			n = axis(16'($urandom_range(0, 2)), 16'($urandom_range(0, 6) - 3),
				16'($urandom_range(0, 6) - 3));
		end
		for (int k = 0; k < 3; k++)
			c[k] = ($urandom_range(0, 9) < 7) ? 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24))
				: $urandom;
		calm = ($urandom_range(0, 3) == 0);
		set_frame(c[0], c[1], c[2], h, n, 2'($urandom_range(0, 3)));
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			for (int k = 0; k < 3; k++) begin
				if (r < 60) p[k] = c[k] + 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
				else if (r < 85) p[k] = $urandom;
				else if (r < 95) p[k] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				else p[k] = c[k];                                // zero offset
			end
			if (r >= 55 && r < 62) p[1] = '0;                 // zero divisor in divide mode
			send_point(p[0], p[1], p[2]);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame: identity-like axes, transform only
		send_point('0, '0, '0);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(ONE, 2 * ONE, 3 * ONE);

		// extreme camera offset saturates the transform
		set_frame(32'h80000000, 32'h7fffffff, '0, axis(AX_ONE, 16'd0, 16'd0),
			axis(16'd0, 16'd0, AX_ONE), cfpt_pkg::MODE_XF);
		send_point(32'h7fffffff, 32'h80000000, 5 * ONE);
		send_point('0, '0, '0);

		// parallel axes give a singular basis
		set_frame(ONE, ONE, ONE, axis(AX_ONE, 16'd0, 16'd0), axis(AX_ONE, 16'd0, 16'd0),
			MODE_BOTH);
		send_point(ONE, ONE, ONE);

		// unit-lsb axes, inverse entries out of range
		set_frame('0, '0, '0, axis(16'd1, 16'd0, 16'd0), axis(16'd0, 16'd1, 16'd0),
			cfpt_pkg::MODE_XF);
		send_point(ONE, 32'hffff0000, 7);

		// divide only: zero divisor, quotient overflow, plain case
		set_frame('0, '0, '0, axis(AX_ONE, 16'd0, 16'd0), axis(16'd0, AX_ONE, 16'd0),
			cfpt_pkg::MODE_DIV);
		send_point(ONE, '0, ONE);
		send_point(32'h7fffffff, 32'd1, 32'h80000000);
		send_point(3 * ONE, 2 * ONE, 32'hffff0000);

		// tilted axes, mode 3 acts as transform then divide; point at camera -> zero divisor
		set_frame(32'h0002_8000, 32'hfffe_0000, 32'h0000_4000,
			axis(16'sd11585, 16'sd11585, 16'd0), axis(16'd0, 16'sh8000, 16'sd8192),
			MODE_BOTH_ALT);
		write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
		@(posedge clk);
		send_point(32'h0002_8000, 32'hfffe_0000, 32'h0000_4000);
		send_point(5 * ONE, 9 * ONE, 32'hfff0_0000);
		send_point(32'h80000000, 32'h7fffffff, 32'h12345678);

		for (int ph = 0; ph < 10; ph++) random_phase(100);

		calm = 1'b0;
		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
